// File: src/kdkf_pkg.sv
// ----------------------------------------------------------------------------
// kdkf_pkg
// Shared types and constants for the keypad debouncer with key ring.
// ----------------------------------------------------------------------------
`default_nettype none

package kdkf_pkg;

  // ring geometry
  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PEND_W     = PTR_W + 1;

  // configuration bus
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // request codes
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_KEY_MASK     = 3'd0,
    REG_DEBOUNCE_MIN = 3'd1,
    REG_DEBOUNCE_MAX = 3'd2,
    REG_CODE_MENU    = 3'd3,
    REG_CODE_UP      = 3'd4,
    REG_CODE_DOWN    = 3'd5,
    REG_CODE_ENTER   = 3'd6,
    REG_CODE_ESCAPE  = 3'd7
  } reg_idx_t;

  // reset values of the registers
  localparam logic [7:0] RST_KEY_MASK     = 8'd31;
  localparam logic [7:0] RST_DEBOUNCE_MIN = 8'd3;
  localparam logic [7:0] RST_DEBOUNCE_MAX = 8'd10;
  localparam logic [7:0] RST_CODE_MENU    = 8'd1;
  localparam logic [7:0] RST_CODE_UP      = 8'd2;
  localparam logic [7:0] RST_CODE_DOWN    = 8'd4;
  localparam logic [7:0] RST_CODE_ENTER   = 8'd8;
  localparam logic [7:0] RST_CODE_ESCAPE  = 8'd16;

  // register file contents
  typedef struct packed {
    logic [7:0] key_mask;
    logic [7:0] debounce_min;
    logic [7:0] debounce_max;
    logic [7:0] code_menu;
    logic [7:0] code_up;
    logic [7:0] code_down;
    logic [7:0] code_enter;
    logic [7:0] code_escape;
  } cfg_t;

  // ring requests for one transaction
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] push_data;
  } ring_ctrl_t;

  // ring status after the current request
  typedef struct packed {
    logic [7:0]        rd_data;
    logic [PEND_W-1:0] pend;
  } ring_stat_t;

endpackage

`default_nettype wire

// File: src/kdkf_if.sv
// ----------------------------------------------------------------------------
// kdkf_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdkf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] port_value;
  logic [4:0] min_count;

  modport source (output valid, func, port_value, min_count, input ready);
  modport sink   (input valid, func, port_value, min_count, output ready);
endinterface

interface kdkf_out_if;
  logic       valid;
  logic       ready;
  logic       new_key_valid;
  logic [7:0] new_key_code;
  logic [7:0] popped_key;
  logic [3:0] pending_count;

  modport source (output valid, new_key_valid, new_key_code, popped_key, pending_count,
                  input ready);
  modport sink   (input valid, new_key_valid, new_key_code, popped_key, pending_count,
                  output ready);
endinterface

`default_nettype wire

// File: src/kdkf_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdkf_cfg_regs
// APB register file holding mask, debounce limits and key codes.
// ----------------------------------------------------------------------------
`default_nettype none

module kdkf_cfg_regs
  import kdkf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  reg_idx_t   idx;
  logic       wr_en;
  logic [7:0] wbyte;
  logic [7:0] rbyte;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wbyte  = pwdata[7:0];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_mask     <= RST_KEY_MASK;
      cfg_r.debounce_min <= RST_DEBOUNCE_MIN;
      cfg_r.debounce_max <= RST_DEBOUNCE_MAX;
      cfg_r.code_menu    <= RST_CODE_MENU;
      cfg_r.code_up      <= RST_CODE_UP;
      cfg_r.code_down    <= RST_CODE_DOWN;
      cfg_r.code_enter   <= RST_CODE_ENTER;
      cfg_r.code_escape  <= RST_CODE_ESCAPE;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_MASK:     cfg_r.key_mask     <= wbyte;
        REG_DEBOUNCE_MIN: cfg_r.debounce_min <= wbyte;
        REG_DEBOUNCE_MAX: cfg_r.debounce_max <= wbyte;
        REG_CODE_MENU:    cfg_r.code_menu    <= wbyte;
        REG_CODE_UP:      cfg_r.code_up      <= wbyte;
        REG_CODE_DOWN:    cfg_r.code_down    <= wbyte;
        REG_CODE_ENTER:   cfg_r.code_enter   <= wbyte;
        REG_CODE_ESCAPE:  cfg_r.code_escape  <= wbyte;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_KEY_MASK:     rbyte = cfg_r.key_mask;
      REG_DEBOUNCE_MIN: rbyte = cfg_r.debounce_min;
      REG_DEBOUNCE_MAX: rbyte = cfg_r.debounce_max;
      REG_CODE_MENU:    rbyte = cfg_r.code_menu;
      REG_CODE_UP:      rbyte = cfg_r.code_up;
      REG_CODE_DOWN:    rbyte = cfg_r.code_down;
      REG_CODE_ENTER:   rbyte = cfg_r.code_enter;
      REG_CODE_ESCAPE:  rbyte = cfg_r.code_escape;
      default:          rbyte = 8'd0;
    endcase
  end

  assign prdata = CFG_DATA_W'(rbyte);

endmodule

`default_nettype wire

// File: src/kdkf_debounce.sv
// ----------------------------------------------------------------------------
// kdkf_debounce
// Stable-sample counter with key code match and auto-repeat restart.
// ----------------------------------------------------------------------------
`default_nettype none

module kdkf_debounce
  import kdkf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       step,
  input  wire logic [7:0] port_value,
  output logic            push,
  output logic [7:0]      push_code
);

  logic [7:0] last_pattern_r, last_pattern_nxt;
  logic [7:0] stable_cnt_r, stable_cnt_nxt;
  logic [7:0] pat;
  logic [7:0] cnt_upd;
  logic       is_code;

  // invert active-low port and keep key lines only
  assign pat     = ~port_value & cfg.key_mask;
  assign is_code = (pat == cfg.code_menu) || (pat == cfg.code_up) ||
                   (pat == cfg.code_down) || (pat == cfg.code_enter) ||
                   (pat == cfg.code_escape);
  assign cnt_upd = (last_pattern_r != pat) ? 8'd0 : stable_cnt_r + 8'd1;

  // next count, pattern and key acceptance
  always_comb begin
    last_pattern_nxt = last_pattern_r;
    stable_cnt_nxt   = stable_cnt_r;
    push             = 1'b0;
    if (step) begin
      if (pat != 8'd0) begin
        last_pattern_nxt = pat;
        stable_cnt_nxt   = cnt_upd;
        if (cnt_upd == cfg.debounce_min) begin
          push = is_code;
        end else if (cnt_upd >= cfg.debounce_max) begin
          stable_cnt_nxt = 8'd0;
        end
      end else begin
        stable_cnt_nxt = 8'd0;
      end
    end
  end

  assign push_code = pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pattern_r <= 8'd0;
      stable_cnt_r   <= 8'd0;
    end else begin
      last_pattern_r <= last_pattern_nxt;
      stable_cnt_r   <= stable_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/kdkf_ring.sv
// ----------------------------------------------------------------------------
// kdkf_ring
// Key ring without full or empty checks, with per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kdkf_ring
  import kdkf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ring_ctrl_t ctrl,
  output ring_stat_t      stat
);

  logic [7:0]            ring_r [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [PTR_W-1:0]      wptr_r, wptr_nxt;
  logic [PTR_W-1:0]      rptr_r, rptr_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] q;
    q = {1'b0, p} + 1'b1;
    return (q >= (PTR_W+1)'(RING_DEPTH)) ? '0 : q[PTR_W-1:0];
  endfunction

  // pointer updates
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (ctrl.clear) begin
      wptr_nxt = '0;
      rptr_nxt = '0;
    end else begin
      if (ctrl.push) wptr_nxt = ptr_inc(wptr_r);
      if (ctrl.pop)  rptr_nxt = ptr_inc(rptr_r);
    end
  end

  // entry at read pointer, reset value until written
  assign stat.rd_data = vld_r[rptr_r] ? ring_r[rptr_r] : 8'd0;

  // keys waiting after this request
  assign stat.pend = (wptr_nxt >= rptr_nxt) ?
                     PEND_W'(wptr_nxt - rptr_nxt) :
                     PEND_W'(RING_DEPTH) + PEND_W'(wptr_nxt) - PEND_W'(rptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      vld_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      if (ctrl.push) vld_r[wptr_r] <= 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (ctrl.push) ring_r[wptr_r] <= ctrl.push_data;
  end

endmodule

`default_nettype wire

// File: src/keypad_debounce_key_fifo_top.sv
// ----------------------------------------------------------------------------
// keypad_debounce_key_fifo_top
// Keypad debouncer with a key ring and APB configuration.
// ----------------------------------------------------------------------------
// flow: an accepted request is held in the request register and its result in the
//   result register; one transaction per cycle while out_chan does not stall; the
//   two registers form a two-stage pipeline, all debounce and ring work is done between them
// reset: synchronous active-low; registers return to defaults, pointers, count
//   and pattern clear, ring entries read as zero until written
`default_nettype none

module keypad_debounce_key_fifo_top
  import kdkf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  kdkf_in_if.sink                    in_chan,
  kdkf_out_if.source                 out_chan,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t       cfg;
  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;

  logic       s1_valid_r;
  func_t      s1_func_r;
  logic [7:0] s1_port_r;
  logic [4:0] s1_minc_r;
  logic       s1_adv;
  logic       in_fire;

  logic       out_valid_r;
  logic       out_nkv_r;
  logic [7:0] out_code_r;
  logic [7:0] out_pop_r;
  logic [3:0] out_pend_r;

  logic       do_sample;
  logic       push;
  logic [7:0] push_code;
  logic [15:0] pend_ext;
  logic [3:0] pend_rep;

  // handshake
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= func_t'(in_chan.func);
      s1_port_r <= in_chan.port_value;
      s1_minc_r <= in_chan.min_count;
    end
  end

  kdkf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign do_sample = s1_adv && (s1_func_r == FUNC_SAMPLE);

  kdkf_debounce u_deb (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (do_sample),
    .port_value (s1_port_r),
    .push       (push),
    .push_code  (push_code)
  );

  // ring requests
  assign ring_ctrl.push      = push;
  assign ring_ctrl.push_data = push_code;
  assign ring_ctrl.pop       = s1_adv && (s1_func_r == FUNC_POP);
  assign ring_ctrl.clear     = s1_adv && (s1_func_r == FUNC_CLEAR);

  kdkf_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ring_ctrl),
    .stat  (ring_stat)
  );

  // pending count: zero below threshold, saturate at 15
  assign pend_ext = 16'(ring_stat.pend);
  always_comb begin
    priority if (pend_ext < 16'(s1_minc_r)) begin
      pend_rep = 4'd0;
    end else if (pend_ext > 16'd15) begin
      pend_rep = 4'd15;
    end else begin
      pend_rep = pend_ext[3:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_nkv_r  <= push;
      out_code_r <= push ? push_code : 8'd0;
      out_pop_r  <= ring_ctrl.pop ? ring_stat.rd_data : 8'd0;
      out_pend_r <= pend_rep;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.new_key_valid = out_nkv_r;
  assign out_chan.new_key_code  = out_code_r;
  assign out_chan.popped_key    = out_pop_r;
  assign out_chan.pending_count = out_pend_r;

endmodule

`default_nettype wire
